// ----- hw/rtl/adc_osr_pkg.sv -----
// Package: shared types, register map, masks and reset values of the ADC one-shot register block
package adc_osr_pkg;

    localparam int FUNC_W   = 3;
    localparam int OFFSET_W = 10;
    localparam int WORD_W   = 32;
    localparam int CODE_W   = 12;
    localparam int CHAN_W   = 3;
    localparam int ATTEN_W  = 2;
    localparam int COUNT_W  = 30;
    localparam int ENA_W    = 6;
    localparam int ONESHOT_W = 9;
    localparam int CW2_W    = 25;

    localparam logic [WORD_W-1:0] MAX_DELAY_TICKS = 32'd1000000000;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CODE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELAY = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd4;

    localparam logic [OFFSET_W-1:0] OFF_CTRL    = 10'h000;
    localparam logic [OFFSET_W-1:0] OFF_CTRL2   = 10'h004;
    localparam logic [OFFSET_W-1:0] OFF_ONESHOT = 10'h020;
    localparam logic [OFFSET_W-1:0] OFF_ARB     = 10'h024;
    localparam logic [OFFSET_W-1:0] OFF_DATA    = 10'h02c;
    localparam logic [OFFSET_W-1:0] OFF_INT_ENA = 10'h040;
    localparam logic [OFFSET_W-1:0] OFF_INT_RAW = 10'h044;
    localparam logic [OFFSET_W-1:0] OFF_INT_ST  = 10'h048;
    localparam logic [OFFSET_W-1:0] OFF_INT_CLR = 10'h04c;
    localparam logic [OFFSET_W-1:0] OFF_CLK     = 10'h054;

    localparam logic [WORD_W-1:0] CTRL_MASK  = 32'hd883ffc3;
    localparam logic [WORD_W-1:0] CTRL2_MASK = 32'h01fff7ff;

    localparam logic [WORD_W-1:0]    CTRL_RESET    = 32'h40038240;
    localparam logic [CW2_W-1:0]     CTRL2_RESET   = 25'h000a1fe;
    localparam logic [ONESHOT_W-1:0] ONESHOT_RESET = 9'h034;
    localparam logic [WORD_W-1:0]    ARB_RESET     = 32'h00000900;
    localparam logic [WORD_W-1:0]    CLK_RESET     = 32'h00000004;

    localparam int CW2_INVERT_BIT   = 9;
    localparam int CW2_TIMERSCAN_BIT = 24;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [OFFSET_W-1:0] reg_offset;
        logic [WORD_W-1:0]   write_data;
        logic [WORD_W-1:0]   backend_value;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]  read_data;
        logic               irq_line;
        logic               request_pending;
        logic [CHAN_W-1:0]  chosen_channel;
        logic [ATTEN_W-1:0] chosen_attenuation;
        logic [WORD_W-1:0]  request_total;
        logic               backend_rejected;
        logic               unmodeled_access;
    } rsp_t;

    typedef struct packed {
        logic pending;
        logic scheduled;
        logic code_valid;
        logic raw_done;
    } status_t;

endpackage

// ----- hw/rtl/adc_osr_cmd_if.sv -----
// Interface: command channel carrying bus accesses, backend events and ticks
interface adc_osr_cmd_if;
    import adc_osr_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [OFFSET_W-1:0] reg_offset;
    logic [WORD_W-1:0]   write_data;
    logic [WORD_W-1:0]   backend_value;

    modport source (output valid, func, reg_offset, write_data, backend_value, input ready);
    modport sink (input valid, func, reg_offset, write_data, backend_value, output ready);
endinterface

// ----- hw/rtl/adc_osr_rsp_if.sv -----
// Interface: result channel carrying read data and block status
interface adc_osr_rsp_if;
    import adc_osr_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  read_data;
    logic               irq_line;
    logic               request_pending;
    logic [CHAN_W-1:0]  chosen_channel;
    logic [ATTEN_W-1:0] chosen_attenuation;
    logic [WORD_W-1:0]  request_total;
    logic               backend_rejected;
    logic               unmodeled_access;

    modport source (output valid, read_data, irq_line, request_pending, chosen_channel,
                    chosen_attenuation, request_total, backend_rejected, unmodeled_access,
                    input ready);
    modport sink (input valid, read_data, irq_line, request_pending, chosen_channel,
                  chosen_attenuation, request_total, backend_rejected, unmodeled_access,
                  output ready);
endinterface

// ----- hw/rtl/adc_osr_core.sv -----
// Register file, one-shot request control and conversion countdown
module adc_osr_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  adc_osr_pkg::cmd_t    cmd,
    output adc_osr_pkg::rsp_t    rsp_next,
    output adc_osr_pkg::status_t status
);
    import adc_osr_pkg::*;

    logic [WORD_W-1:0]    ctrl_reg, ctrl_next;
    logic [CW2_W-1:0]     ctrl2_reg, ctrl2_next;
    logic [ONESHOT_W-1:0] oneshot_reg, oneshot_next;
    logic [WORD_W-1:0]    arb_reg, arb_next;
    logic [WORD_W-1:0]    clkw_reg, clkw_next;
    logic                 raw_reg, raw_next;
    logic [ENA_W-1:0]     ena_reg, ena_next;
    logic [CODE_W-1:0]    result_reg, result_next;
    logic [CHAN_W-1:0]    chan_reg, chan_next;
    logic [ATTEN_W-1:0]   atten_reg, atten_next;
    logic                 pending_reg, pending_next;
    logic                 code_valid_reg, code_valid_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 sched_reg, sched_next;
    logic [WORD_W-1:0]    total_reg, total_next;

    logic [WORD_W-1:0] rd;
    logic              unk;
    logic              rej;
    logic              start;
    logic              rising;
    logic [3:0]        ch;
    logic              req_ok;

    always_comb
    begin
        ctrl_next       = ctrl_reg;
        ctrl2_next      = ctrl2_reg;
        oneshot_next    = oneshot_reg;
        arb_next        = arb_reg;
        clkw_next       = clkw_reg;
        raw_next        = raw_reg;
        ena_next        = ena_reg;
        result_next     = result_reg;
        chan_next       = chan_reg;
        atten_next      = atten_reg;
        pending_next    = pending_reg;
        code_valid_next = code_valid_reg;
        code_next       = code_reg;
        count_next      = count_reg;
        sched_next      = sched_reg;
        total_next      = total_reg;
        rd  = '0;
        unk = 1'b0;
        rej = 1'b0;

        start  = cmd.write_data[29];
        rising = start && !oneshot_reg[6];
        ch     = cmd.write_data[28:25];
        req_ok = (cmd.write_data[31:30] == 2'b10) && (ch <= 4'd4)
                 && !ctrl2_reg[CW2_TIMERSCAN_BIT];

        case (cmd.func)
            FUNC_READ:
            begin
                case (cmd.reg_offset)
                    OFF_CTRL:    rd = ctrl_reg;
                    OFF_CTRL2:   rd = {{(WORD_W-CW2_W){1'b0}}, ctrl2_reg};
                    OFF_ONESHOT: rd = {oneshot_reg, {(WORD_W-ONESHOT_W){1'b0}}};
                    OFF_ARB:     rd = arb_reg;
                    OFF_DATA:    rd = {{(WORD_W-CODE_W){1'b0}}, result_reg};
                    OFF_INT_ENA: rd = {ena_reg, {(WORD_W-ENA_W){1'b0}}};
                    OFF_INT_RAW: rd = {raw_reg, {(WORD_W-1){1'b0}}};
                    OFF_INT_ST:  rd = {raw_reg & ena_reg[ENA_W-1], {(WORD_W-1){1'b0}}};
                    OFF_INT_CLR: rd = '0;
                    OFF_CLK:     rd = clkw_reg;
                    default:     unk = 1'b1;
                endcase
            end
            FUNC_WRITE:
            begin
                case (cmd.reg_offset)
                    OFF_CTRL:    ctrl_next = cmd.write_data & CTRL_MASK;
                    OFF_CTRL2:
                    begin
                        ctrl2_next = cmd.write_data[CW2_W-1:0] & CTRL2_MASK[CW2_W-1:0];
                        unk        = cmd.write_data[CW2_TIMERSCAN_BIT];
                    end
                    OFF_ARB:     arb_next = cmd.write_data;
                    OFF_CLK:     clkw_next = cmd.write_data;
                    OFF_ONESHOT:
                    begin
                        oneshot_next = cmd.write_data[31:23];
                        if (!start)
                        begin
                            pending_next    = 1'b0;
                            code_valid_next = 1'b0;
                            sched_next      = 1'b0;
                            count_next      = '0;
                        end
                        if (rising)
                        begin
                            if (!req_ok)
                            begin
                                unk = 1'b1;
                            end
                            else
                            begin
                                chan_next       = ch[CHAN_W-1:0];
                                atten_next      = cmd.write_data[24:23];
                                total_next      = total_reg + 32'd1;
                                pending_next    = 1'b1;
                                code_valid_next = 1'b0;
                            end
                        end
                    end
                    OFF_INT_ENA: ena_next = cmd.write_data[31:26];
                    OFF_INT_CLR:
                    begin
                        if (cmd.write_data[31])
                            raw_next = 1'b0;
                    end
                    default:     unk = 1'b1;
                endcase
            end
            FUNC_CODE:
            begin
                if (!pending_reg || sched_reg || (cmd.backend_value[WORD_W-1:CODE_W] != '0))
                begin
                    rej = 1'b1;
                end
                else
                begin
                    code_valid_next = 1'b1;
                    code_next       = cmd.backend_value[CODE_W-1:0];
                end
            end
            FUNC_DELAY:
            begin
                if (!pending_reg || sched_reg || !code_valid_reg ||
                    (cmd.backend_value == '0) || (cmd.backend_value > MAX_DELAY_TICKS))
                begin
                    rej = 1'b1;
                end
                else
                begin
                    count_next = cmd.backend_value[COUNT_W-1:0];
                    sched_next = 1'b1;
                end
            end
            FUNC_TICK:
            begin
                if (sched_reg)
                begin
                    if (count_reg[COUNT_W-1:1] == '0)
                    begin
                        sched_next = 1'b0;
                        count_next = '0;
                        if (pending_reg)
                        begin
                            result_next     = code_reg ^ {CODE_W{ctrl2_reg[CW2_INVERT_BIT]}};
                            pending_next    = 1'b0;
                            code_valid_next = 1'b0;
                            raw_next        = 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = count_reg - 30'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        rsp_next.read_data          = rd;
        rsp_next.irq_line           = raw_next & ena_next[ENA_W-1];
        rsp_next.request_pending    = pending_next;
        rsp_next.chosen_channel     = chan_next;
        rsp_next.chosen_attenuation = atten_next;
        rsp_next.request_total      = total_next;
        rsp_next.backend_rejected   = rej;
        rsp_next.unmodeled_access   = unk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg       <= CTRL_RESET;
            ctrl2_reg      <= CTRL2_RESET;
            oneshot_reg    <= ONESHOT_RESET;
            arb_reg        <= ARB_RESET;
            clkw_reg       <= CLK_RESET;
            raw_reg        <= 1'b0;
            ena_reg        <= '0;
            result_reg     <= '0;
            chan_reg       <= '0;
            atten_reg      <= '0;
            pending_reg    <= 1'b0;
            code_valid_reg <= 1'b0;
            count_reg      <= '0;
            sched_reg      <= 1'b0;
            total_reg      <= '0;
        end
        else if (step)
        begin
            ctrl_reg       <= ctrl_next;
            ctrl2_reg      <= ctrl2_next;
            oneshot_reg    <= oneshot_next;
            arb_reg        <= arb_next;
            clkw_reg       <= clkw_next;
            raw_reg        <= raw_next;
            ena_reg        <= ena_next;
            result_reg     <= result_next;
            chan_reg       <= chan_next;
            atten_reg      <= atten_next;
            pending_reg    <= pending_next;
            code_valid_reg <= code_valid_next;
            count_reg      <= count_next;
            sched_reg      <= sched_next;
            total_reg      <= total_next;
        end
    end

    // held code is payload, qualified by code_valid_reg
    always_ff @(posedge clk)
    begin
        if (step)
            code_reg <= code_next;
    end

    assign status.pending    = pending_reg;
    assign status.scheduled  = sched_reg;
    assign status.code_valid = code_valid_reg;
    assign status.raw_done   = raw_reg;

endmodule

// ----- hw/rtl/adc_oneshot_register_block.sv -----
// Top level: input register, register core and result register of the ADC one-shot block
// An accepted item waits in the input register until its result enters the result register.
// Throughput: one item per cycle unless an unread result stalls it; one pass updates all state.
// The input stage keeps accepting while a result waits, up to one item held.
// Reset: asynchronous, active low; registers return to their documented reset values,
// no request pending, no countdown running, both pipeline stages empty.
module adc_oneshot_register_block (
    input  logic clk,
    input  logic rst_n,
    adc_osr_cmd_if.sink   cmd,
    adc_osr_rsp_if.source rsp
);
    import adc_osr_pkg::*;

    logic    cmd_valid_reg;
    cmd_t    cmd_data_reg;
    logic    rsp_valid_reg;
    rsp_t    rsp_data_reg;
    rsp_t    rsp_next;
    status_t status;
    logic    advance;

    assign advance   = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !cmd_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
                cmd_valid_reg <= cmd.valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_data_reg.func          <= cmd.func;
            cmd_data_reg.reg_offset    <= cmd.reg_offset;
            cmd_data_reg.write_data    <= cmd.write_data;
            cmd_data_reg.backend_value <= cmd.backend_value;
        end
        if (advance)
            rsp_data_reg <= rsp_next;
    end

    adc_osr_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .cmd      (cmd_data_reg),
        .rsp_next (rsp_next),
        .status   (status)
    );

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.read_data          = rsp_data_reg.read_data;
    assign rsp.irq_line           = rsp_data_reg.irq_line;
    assign rsp.request_pending    = rsp_data_reg.request_pending;
    assign rsp.chosen_channel     = rsp_data_reg.chosen_channel;
    assign rsp.chosen_attenuation = rsp_data_reg.chosen_attenuation;
    assign rsp.request_total      = rsp_data_reg.request_total;
    assign rsp.backend_rejected   = rsp_data_reg.backend_rejected;
    assign rsp.unmodeled_access   = rsp_data_reg.unmodeled_access;

    a_sched_needs_code: assert property (@(posedge clk) disable iff (!rst_n)
        status.scheduled |-> (status.pending && status.code_valid))
        else $error("countdown running without a pending request and held code");

    a_done_from_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(status.raw_done) |-> $past(status.scheduled))
        else $error("done interrupt raised without a running countdown");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_data_reg.backend_rejected && rsp_data_reg.unmodeled_access))
        else $error("result flags both raised for one item");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && !advance) |=> $stable(status))
        else $error("core state changed while the item was stalled");

endmodule
